/* hdl/sdm_pkg.sv */
// ----------------------------------------------------------------------------
// sdm_pkg
// shared types and constants for the signed divide / modulo block
// ----------------------------------------------------------------------------
package sdm_pkg;

    localparam int MAX_BYTES           = 8;
    localparam int DEFAULT_VALUE_BYTES = 8;
    localparam int PORT_WIDTH          = 64;

    localparam logic OP_QUOT = 1'b0;
    localparam logic OP_REM  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_DIV0 = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_FIX
    } sdm_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic step;
        logic fix;
    } sdm_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic div_zero;
    } sdm_sts_t;

endpackage

/* hdl/sdm_ctrl.sv */
// ----------------------------------------------------------------------------
// sdm_ctrl
// sequencer: load, sign prep, one quotient bit per cycle, sign fix-up
// ----------------------------------------------------------------------------
module sdm_ctrl
    import sdm_pkg::*;
#(
    parameter int WIDTH = 8 * DEFAULT_VALUE_BYTES
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  sdm_sts_t sts,
    output sdm_cmd_t cmd,
    output logic     busy,
    output logic     done
);

    localparam int CW = $clog2(WIDTH);

    sdm_state_t      state_reg;
    sdm_state_t      state_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            done_reg;
    logic            done_next;
    logic            last;

    assign last = (count_reg == CW'(WIDTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                if (sts.div_zero)
                    state_next = S_FIX;
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (last)
                    state_next = S_FIX;
            end
            S_FIX:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd        = '0;
        count_next = count_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                count_next = '0;
            end
            S_DIV:
            begin
                cmd.step   = 1'b1;
                count_next = count_reg + 1'b1;
            end
            S_FIX:
            begin
                cmd.fix   = 1'b1;
                done_next = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_PREP))
        else $error("accepted beat did not enter prep");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while busy");

    a_last_fix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && last) |=> (state_reg == S_FIX))
        else $error("divide loop did not end after last bit");

    a_zero_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PREP && sts.div_zero) |=> (state_reg == S_FIX))
        else $error("zero divisor did not skip the divide loop");

endmodule

/* hdl/sdm_dpath.sv */
// ----------------------------------------------------------------------------
// sdm_dpath
// operand registers, sign prep, restoring divide step and sign fix-up of the result
// ----------------------------------------------------------------------------
module sdm_dpath
    import sdm_pkg::*;
#(
    parameter int WIDTH = 8 * DEFAULT_VALUE_BYTES
)
(
    input  logic                  clk,
    input  sdm_cmd_t              cmd,
    output sdm_sts_t              sts,
    input  logic                  opcode,
    input  logic [PORT_WIDTH-1:0] dividend,
    input  logic                  dividend_signed,
    input  logic [PORT_WIDTH-1:0] divisor,
    input  logic                  divisor_signed,
    output logic [PORT_WIDTH-1:0] result,
    output logic                  result_signed,
    output logic                  status
);

    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] rem_reg;
    logic             op_reg;
    logic             as_reg;
    logic             bs_reg;
    logic             neg_reg;
    logic             zero_reg;
    logic [WIDTH-1:0] res_reg;
    logic             rsgn_reg;
    logic             stat_reg;

    logic             a_neg;
    logic             b_neg;
    logic [WIDTH:0]   trial;
    logic [WIDTH-1:0] mag;

    assign a_neg        = as_reg & a_reg[WIDTH-1];
    assign b_neg        = bs_reg & b_reg[WIDTH-1];
    assign sts.div_zero = (b_reg == '0);

    // shifted partial remainder minus divisor, top bit set means restore
    assign trial = {rem_reg, a_reg[WIDTH-1]} - {1'b0, b_reg};
    assign mag   = (op_reg == OP_QUOT) ? a_reg : rem_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg  <= dividend[WIDTH-1:0];
            b_reg  <= divisor[WIDTH-1:0];
            op_reg <= opcode;
            as_reg <= dividend_signed;
            bs_reg <= divisor_signed;
        end
        if (cmd.prep)
        begin
            a_reg    <= a_neg ? (WIDTH'(0) - a_reg) : a_reg;
            b_reg    <= b_neg ? (WIDTH'(0) - b_reg) : b_reg;
            rem_reg  <= '0;
            zero_reg <= sts.div_zero;
            neg_reg  <= (op_reg == OP_QUOT) ? (a_neg ^ b_neg) : a_neg;
        end
        if (cmd.step)
        begin
            if (!trial[WIDTH])
            begin
                rem_reg <= trial[WIDTH-1:0];
                a_reg   <= {a_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[WIDTH-2:0], a_reg[WIDTH-1]};
                a_reg   <= {a_reg[WIDTH-2:0], 1'b0};
            end
        end
        if (cmd.fix)
        begin
            if (zero_reg)
            begin
                res_reg  <= '0;
                rsgn_reg <= 1'b0;
                stat_reg <= STATUS_DIV0;
            end
            else
            begin
                res_reg  <= neg_reg ? (WIDTH'(0) - mag) : mag;
                rsgn_reg <= neg_reg;
                stat_reg <= STATUS_OK;
            end
        end
    end

    assign result        = PORT_WIDTH'(res_reg);
    assign result_signed = rsgn_reg;
    assign status        = stat_reg;

endmodule

/* hdl/signed_divide_modulo.sv */
// ----------------------------------------------------------------------------
// signed_divide_modulo
// truncating divide / modulo of words with per-operand signedness
// ----------------------------------------------------------------------------
// usage:
//   drive opcode, dividend, divisor and their signed flags with start high;
//   the beat is taken at a clock edge where start is high and busy is low.
//   only the low 8*VALUE_BYTES bits of dividend and divisor are used.
//   busy stays high while the item is worked on; one item at a time.
//   sequence: after the accepting edge come a sign prep state, the restoring
//   divide loop at one quotient bit per cycle and a sign fix-up state, then
//   done is high for exactly one cycle with result, result_signed and
//   status. a zero divisor skips the loop and goes straight to fix-up.
//   back to back: a new start is taken in the cycle done is shown; the
//   block takes no new item before the last one is through.
//   the receiver cannot stall; a result must be taken while done is high.
//   reset clears the sequencer and drops busy and done at once.
// ----------------------------------------------------------------------------
module signed_divide_modulo
    import sdm_pkg::*;
#(
    parameter int VALUE_BYTES = DEFAULT_VALUE_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  opcode,
    input  logic [PORT_WIDTH-1:0] dividend,
    input  logic                  dividend_signed,
    input  logic [PORT_WIDTH-1:0] divisor,
    input  logic                  divisor_signed,
    output logic                  done,
    output logic [PORT_WIDTH-1:0] result,
    output logic                  result_signed,
    output logic                  status
);

    localparam int BYTES = (VALUE_BYTES < 1) ? 1 :
                           (VALUE_BYTES > MAX_BYTES) ? MAX_BYTES : VALUE_BYTES;
    localparam int WIDTH = 8 * BYTES;

    sdm_cmd_t cmd;
    sdm_sts_t sts;

    sdm_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    sdm_dpath #(
        .WIDTH (WIDTH)
    ) u_dpath (
        .clk             (clk),
        .cmd             (cmd),
        .sts             (sts),
        .opcode          (opcode),
        .dividend        (dividend),
        .dividend_signed (dividend_signed),
        .divisor         (divisor),
        .divisor_signed  (divisor_signed),
        .result          (result),
        .result_signed   (result_signed),
        .status          (status)
    );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for signed_divide_modulo
// queue-fed driver and clocked monitor; every beat is checked field by field
// against a local model of truncating signed / unsigned divide and modulo
// ----------------------------------------------------------------------------
module testbench;
    import sdm_pkg::*;

    localparam int VB          = DEFAULT_VALUE_BYTES;
    localparam int LATENCY     = 8 * VB + 3;
    localparam int RANDOM_EACH = 410;

    typedef struct {
        logic            op;
        logic [63:0]     num;
        logic            num_is_signed;
        logic [63:0]     den;
        logic            den_signed;
    } div_request_t;

    typedef struct {
        logic [63:0]     value;
        logic            negated;
        logic            st;
    } div_answer_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  opcode = OP_QUOT;
    logic [PORT_WIDTH-1:0] dividend = '0;
    logic                  dividend_signed = 1'b0;
    logic [PORT_WIDTH-1:0] divisor = '0;
    logic                  divisor_signed = 1'b0;
    logic                  done;
    logic [PORT_WIDTH-1:0] result;
    logic                  result_signed;
    logic                  status;

    div_request_t requests_pending[$];
    div_answer_t  answers_due[$];
    div_request_t on_ports;
    int           idle_pct = 0;
    int           mismatches = 0;
    int           beats_in = 0;
    int           n_quot = 0;
    int           n_rem = 0;
    int           n_div0 = 0;
    int           n_neg = 0;

    signed_divide_modulo #(.VALUE_BYTES(VB)) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .dividend        (dividend),
        .dividend_signed (dividend_signed),
        .divisor         (divisor),
        .divisor_signed  (divisor_signed),
        .done            (done),
        .result          (result),
        .result_signed   (result_signed),
        .status          (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic div_answer_t predict_division(div_request_t rq);
        int unsigned bytes;
        logic [63:0] mask;
        logic [63:0] top;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] mag;
        logic        a_neg;
        logic        b_neg;
        logic        neg;
        div_answer_t ans;
        bytes = (VB < 1) ? 1 : ((VB > MAX_BYTES) ? MAX_BYTES : VB);
        mask  = {64{1'b1}} >> (64 - 8 * bytes);
        top   = mask ^ (mask >> 1);
        a     = rq.num & mask;
        b     = rq.den & mask;
        if (b == '0)
        begin
            ans.value   = '0;
            ans.negated = 1'b0;
            ans.st      = STATUS_DIV0;
            return ans;
        end
        a_neg = rq.num_is_signed && ((a & top) != '0);
        b_neg = rq.den_signed && ((b & top) != '0);
        if (a_neg)
            a = (-a) & mask;
        if (b_neg)
            b = (-b) & mask;
        if (rq.op == OP_QUOT)
        begin
            mag = a / b;
            neg = a_neg ^ b_neg;
        end
        else
        begin
            mag = a % b;
            neg = a_neg;
        end
        // negated zero still flags the result as signed
        if (neg)
            mag = (-mag) & mask;
        ans.value   = mag & mask;
        ans.negated = neg;
        ans.st      = STATUS_OK;
        return ans;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    task automatic queue_division(logic op, logic [63:0] a, logic as, logic [63:0] b,
                                  logic bs);
        div_request_t rq;
        rq.op            = op;
        rq.num           = a;
        rq.num_is_signed = as;
        rq.den           = b;
        rq.den_signed    = bs;
        requests_pending.push_back(rq);
    endtask

    // corner, full random, random-width (some inverted) and small signed words
    function automatic logic [63:0] random_word();
        logic [63:0] w;
        int          width;
        w = {$urandom, $urandom};
        case ($urandom_range(9))
            0: w = '0;
            1: w = 64'd1;
            2: w = {64{1'b1}};
            3: w = 64'h8000_0000_0000_0000;
            4: w = 64'h7fff_ffff_ffff_ffff;
            5, 6: ;
            7, 8:
            begin
                width = $urandom_range(64, 1);
                w = w & ({64{1'b1}} >> (64 - width));
                if ($urandom_range(1))
                    w = ~w;
            end
            default:
            begin
                w = 64'($urandom_range(15));
                if ($urandom_range(1))
                    w = -w;
            end
        endcase
        return w;
    endfunction

    // driver: a new beat goes out when the port is free or the current one is taken
    always @(posedge clk)
    begin
        if (rst_n && (!start || !busy))
        begin
            if (start)
            begin
                answers_due.push_back(predict_division(on_ports));
                beats_in++;
            end
            if (requests_pending.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                on_ports = requests_pending.pop_front();
                opcode          <= on_ports.op;
                dividend        <= on_ports.num;
                dividend_signed <= on_ports.num_is_signed;
                divisor         <= on_ports.den;
                divisor_signed  <= on_ports.den_signed;
                start           <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: done lasts one cycle, so every strobe is a beat
    always @(posedge clk)
    begin
        div_answer_t want;
        if (rst_n && done)
        begin
            if (answers_due.size() == 0)
            begin
                report_mismatch("unexpected result", result, '0);
            end
            else
            begin
                want = answers_due.pop_front();
                if (result !== want.value)
                    report_mismatch("result", result, want.value);
                if (result_signed !== want.negated)
                    report_mismatch("result_signed", 64'(result_signed), 64'(want.negated));
                if (status !== want.st)
                    report_mismatch("status", 64'(status), 64'(want.st));
                if (want.st == STATUS_DIV0)
                    n_div0++;
                if (want.negated)
                    n_neg++;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("signed_divide_modulo test failed");
        $finish;
    end

    initial
    begin
        int          phase_idle[4];
        logic        op;
        logic [63:0] b;
        phase_idle = '{0, 46, 0, 13};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        queue_division(OP_QUOT, 64'd100, 1'b0, 64'd7, 1'b0);
        queue_division(OP_REM,  64'd100, 1'b0, 64'd7, 1'b0);
        queue_division(OP_QUOT, 64'd5, 1'b0, 64'd0, 1'b0);
        queue_division(OP_REM,  {64{1'b1}}, 1'b1, 64'd0, 1'b1);
        queue_division(OP_QUOT, 64'd0, 1'b1, 64'd9, 1'b1);
        queue_division(OP_QUOT, {64{1'b1}}, 1'b0, {64{1'b1}}, 1'b0);
        queue_division(OP_REM,  {64{1'b1}}, 1'b0, 64'd1, 1'b0);
        queue_division(OP_QUOT, {64{1'b1}}, 1'b0, 64'd1, 1'b0);
        queue_division(OP_QUOT, -64'd100, 1'b1, 64'd7, 1'b1);
        queue_division(OP_REM,  -64'd100, 1'b1, 64'd7, 1'b1);
        queue_division(OP_QUOT, 64'd100, 1'b1, -64'd7, 1'b1);
        queue_division(OP_REM,  64'd100, 1'b1, -64'd7, 1'b1);
        queue_division(OP_QUOT, -64'd100, 1'b1, -64'd7, 1'b1);
        queue_division(OP_REM,  -64'd100, 1'b1, -64'd7, 1'b1);
        // negative dividend read without sign
        queue_division(OP_QUOT, -64'd100, 1'b0, 64'd7, 1'b1);
        // negated zero remainder and negated zero quotient
        queue_division(OP_REM,  -64'd6, 1'b1, 64'd3, 1'b1);
        queue_division(OP_QUOT, 64'd2, 1'b1, -64'd5, 1'b1);
        // most negative value wraps to its own magnitude
        queue_division(OP_QUOT, 64'h8000_0000_0000_0000, 1'b1, {64{1'b1}}, 1'b1);
        queue_division(OP_REM,  64'h8000_0000_0000_0000, 1'b1, {64{1'b1}}, 1'b1);
        queue_division(OP_QUOT, 64'h8000_0000_0000_0000, 1'b1,
                       64'h8000_0000_0000_0000, 1'b1);
        queue_division(OP_QUOT, 64'h7fff_ffff_ffff_ffff, 1'b1,
                       64'h8000_0000_0000_0000, 1'b1);
        queue_division(OP_REM,  64'h7fff_ffff_ffff_ffff, 1'b0,
                       64'h8000_0000_0000_0000, 1'b0);
        queue_division(OP_QUOT, 64'd3, 1'b0, 64'd10, 1'b0);
        queue_division(OP_REM,  64'd3, 1'b0, 64'd10, 1'b0);

        for (int ph = 0; ph < 4; ph++)
        begin
            while (requests_pending.size() != 0 || start || answers_due.size() != 0)
                @(posedge clk);
            idle_pct = phase_idle[ph];
            for (int k = 0; k < RANDOM_EACH; k++)
            begin
                op = 1'($urandom_range(1));
                b  = ($urandom_range(99) < 3) ? 64'd0 : random_word();
                queue_division(op, random_word(), 1'($urandom_range(1)), b,
                               1'($urandom_range(1)));
                if (op == OP_QUOT)
                    n_quot++;
                else
                    n_rem++;
            end
        end

        while (requests_pending.size() != 0 || start || answers_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        if (answers_due.size() != 0)
            report_mismatch("results never returned", 64'(answers_due.size()), '0);

        $display("%0d beats over four idle settings, random part %0d quotients and %0d remainders",
                 beats_in, n_quot, n_rem);
        $display("%0d divide by zero results, %0d negated results, %0d mismatches",
                 n_div0, n_neg, mismatches);
        if (mismatches == 0)
            $display("signed_divide_modulo test passed");
        else
            $display("signed_divide_modulo test failed");
        $finish;
    end

endmodule

/* signed_divide_modulo.f */
hdl/sdm_pkg.sv
hdl/sdm_ctrl.sv
hdl/sdm_dpath.sv
hdl/signed_divide_modulo.sv
tb/sv/testbench.sv
